FILE: design/line_follow_pid_drive_top_assert.svh
// Assertion macros shared by the line follower drive modules.
// Depends on nothing; included by the modules that carry checks.
`ifndef LINE_FOLLOW_PID_DRIVE_TOP_ASSERT_SVH
`define LINE_FOLLOW_PID_DRIVE_TOP_ASSERT_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define LFPD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("%m: check failed");

// Checks that the consequent holds in the cycle after the antecedent.
`define LFPD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("%m: check failed");

`endif

FILE: design/lfpd_pkg.sv
// Shared types, constants and lookup functions of the line follower drive.
// Depends on nothing; every module of the block imports it.
package lfpd_pkg;

	localparam int STATION_COUNT = 7;
	localparam int CNT_W = (STATION_COUNT > 2) ? $clog2(STATION_COUNT) : 1;

	localparam logic [7:0] STOP_SPEED = 8'd65;
	localparam logic signed [5:0] INT_LIM = 6'sd30;

	// Reset values of the configuration registers.
	localparam logic [31:0] GAIN_P_RST = 32'd65536;
	localparam logic [31:0] GAIN_I_RST = 32'd0;
	localparam logic [31:0] GAIN_D_RST = 32'd1507328;
	localparam logic [15:0] MIN_CLEAR_RST = 16'd20;
	localparam logic [15:0] LOST_TIMEOUT_RST = 16'd3000;
	localparam logic [7:0] CRUISE_DRIVE_RST = 8'd75;
	localparam logic [7:0] DRIVE_FLOOR_RST = 8'd72;
	localparam logic [7:0] DRIVE_CEILING_RST = 8'd80;

	localparam int CFG_IDX_W = 3;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_GAIN_P = 3'd0,
		REG_GAIN_I = 3'd1,
		REG_GAIN_D = 3'd2,
		REG_MIN_CLEAR = 3'd3,
		REG_LOST_TIMEOUT = 3'd4,
		REG_CRUISE_DRIVE = 3'd5,
		REG_DRIVE_FLOOR = 3'd6,
		REG_DRIVE_CEILING = 3'd7
	} cfg_reg_t;

	typedef struct packed {
		logic [31:0] gain_p;
		logic [31:0] gain_i;
		logic [31:0] gain_d;
		logic [15:0] min_clear_distance;
		logic [15:0] lost_timeout;
		logic [7:0] cruise_drive;
		logic [7:0] drive_floor;
		logic [7:0] drive_ceiling;
	} cfg_t;

	// What the wheel stage does with an item.
	typedef enum logic [1:0] {
		ACT_HOLD = 2'd0,
		ACT_STOP = 2'd1,
		ACT_PID = 2'd2
	} act_t;

	// Result of the state update stage, handed to the steering datapath.
	typedef struct packed {
		logic vld;
		act_t act;
		logic signed [2:0] err;
		logic signed [5:0] integ;
		logic signed [3:0] dlt;
		logic [2:0] station;
		logic station_event;
		logic halted;
	} track_item_t;

	// Maps the weighted sensor sum, offset by three, to the steering error.
	function automatic logic signed [2:0] err_of_sum(logic [2:0] idx);
		logic signed [2:0] e;
		case (idx)
			3'd0: e = -3'sd2;
			3'd1: e = -3'sd3;
			3'd2: e = -3'sd1;
			3'd3: e = 3'sd0;
			3'd4: e = 3'sd1;
			3'd5: e = 3'sd3;
			3'd6: e = 3'sd2;
			default: e = 3'sd0;
		endcase
		return e;
	endfunction

	// Low three bits of the station counter, whatever its width.
	function automatic logic [2:0] station_out(logic [CNT_W-1:0] cnt);
		logic [CNT_W+2:0] ext;
		ext = {3'b000, cnt};
		return ext[2:0];
	endfunction

endpackage

FILE: design/line_follow_pid_drive_top.sv
// Top level of the line follower wheel drive controller.
// Depends on lfpd_pkg, lfpd_cfg, lfpd_track and lfpd_steer.
//
// The block takes one control tick per clock cycle while in_stall is low and
// returns one result per tick. Each tick passes through the stages in order:
// the sensor and state update logic loads the input stage register at the
// input transaction, the gain multipliers fill the second stage, the speed
// sums the third, and the clamp stage writes the register holding the result.
// Everything that the next tick depends on (integral, previous error, station
// counter and timestamps) is updated in the input stage, so ticks can follow
// back to back. Configuration writes are always ready and should only be
// issued while no tick is in flight.
module line_follow_pid_drive_top import lfpd_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [CFG_IDX_W-1:0] cfg_index,
	input logic [31:0] cfg_data,
	input logic in_valid,
	output logic in_stall,
	input logic [4:0] sensor_bits,
	input logic [15:0] distance_cm,
	input logic [31:0] now_ms,
	output logic out_valid,
	input logic out_stall,
	output logic [7:0] speed_a,
	output logic [7:0] speed_b,
	output logic [2:0] station,
	output logic station_event,
	output logic halted
);

	cfg_t cfg;
	track_item_t item_s1;
	logic take_s1;

	lfpd_cfg u_cfg (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.cfg(cfg)
	);

	lfpd_track u_track (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.sensor_bits(sensor_bits),
		.distance_cm(distance_cm),
		.now_ms(now_ms),
		.take_s1(take_s1),
		.item_s1(item_s1)
	);

	lfpd_steer u_steer (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg),
		.item_s1(item_s1),
		.take_s1(take_s1),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.speed_a(speed_a),
		.speed_b(speed_b),
		.station(station),
		.station_event(station_event),
		.halted(halted)
	);

endmodule

FILE: design/lfpd_cfg.sv
// Configuration register file of the line follower drive.
// Depends on lfpd_pkg for the register indexes and the cfg_t bundle.
module lfpd_cfg import lfpd_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [CFG_IDX_W-1:0] cfg_index,
	input logic [31:0] cfg_data,
	output cfg_t cfg
);

	cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.gain_p <= GAIN_P_RST;
			cfg_q.gain_i <= GAIN_I_RST;
			cfg_q.gain_d <= GAIN_D_RST;
			cfg_q.min_clear_distance <= MIN_CLEAR_RST;
			cfg_q.lost_timeout <= LOST_TIMEOUT_RST;
			cfg_q.cruise_drive <= CRUISE_DRIVE_RST;
			cfg_q.drive_floor <= DRIVE_FLOOR_RST;
			cfg_q.drive_ceiling <= DRIVE_CEILING_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_GAIN_P: cfg_q.gain_p <= cfg_data;
				REG_GAIN_I: cfg_q.gain_i <= cfg_data;
				REG_GAIN_D: cfg_q.gain_d <= cfg_data;
				REG_MIN_CLEAR: cfg_q.min_clear_distance <= cfg_data[15:0];
				REG_LOST_TIMEOUT: cfg_q.lost_timeout <= cfg_data[15:0];
				REG_CRUISE_DRIVE: cfg_q.cruise_drive <= cfg_data[7:0];
				REG_DRIVE_FLOOR: cfg_q.drive_floor <= cfg_data[7:0];
				REG_DRIVE_CEILING: cfg_q.drive_ceiling <= cfg_data[7:0];
			endcase
		end
	end

endmodule

FILE: design/lfpd_track.sv
// Input stage: sensor decoding, station counting, timeouts and integral update.
// Depends on lfpd_pkg; feeds lfpd_steer through a track_item_t register.
`include "line_follow_pid_drive_top_assert.svh"

module lfpd_track import lfpd_pkg::*; (
	input logic clk,
	input logic arst_n,
	input cfg_t cfg,
	input logic in_valid,
	output logic in_stall,
	input logic [4:0] sensor_bits,
	input logic [15:0] distance_cm,
	input logic [31:0] now_ms,
	input logic take_s1,
	output track_item_t item_s1
);

	logic signed [5:0] integral_q, integral_n;
	logic signed [2:0] prev_q, prev_n;
	logic [CNT_W-1:0] station_q, station_n;
	logic latch_q, latch_n;
	logic halt_q, halt_n;
	logic [31:0] last_on_q, last_on_n;
	logic [31:0] last_off_q, last_off_n;
	act_t act_n;
	logic event_n;

	logic s1_ready, accept;
	logic obstacle, mark, offline, mark_to, line_to;
	logic [1:0] pos_w, neg_w;
	logic [2:0] err_idx;
	logic signed [2:0] err;
	logic signed [3:0] dlt;
	logic signed [10:0] ie, ee, x;
	logic [9:0] mag;
	logic [17:0] prod;
	logic [6:0] q;
	logic signed [7:0] iq;
	logic signed [5:0] pid_i;
	logic [31:0] since_off, since_on;
	track_item_t item_q;

	assign s1_ready = !item_q.vld || take_s1;
	assign in_stall = !s1_ready;
	assign accept = in_valid && s1_ready;
	assign item_s1 = item_q;

	// Line seen on the right adds positive weight, on the left negative.
	assign pos_w = {~sensor_bits[4], ~sensor_bits[3]};
	assign neg_w = {~sensor_bits[0], ~sensor_bits[1]};
	assign err_idx = 3'(3'd3 + {1'b0, pos_w} - {1'b0, neg_w});
	assign err = err_of_sum(err_idx);
	assign dlt = {err[2], err} - {prev_q[2], prev_q};

	// New integral is trunc((9*I + 10*e) / 10); the divide by ten uses the
	// reciprocal 205/2048, exact for magnitudes below 1023.
	assign ie = {{5{integral_q[5]}}, integral_q};
	assign ee = {{8{err[2]}}, err};
	assign x = (ie <<< 3) + ie + (ee <<< 3) + (ee <<< 1);
	assign mag = x[10] ? 10'(-x) : x[9:0];
	assign prod = 18'(mag) * 18'd205;
	assign q = prod[17:11];
	assign iq = x[10] ? -$signed({1'b0, q}) : $signed({1'b0, q});
	assign pid_i = (iq > INT_LIM) ? INT_LIM : ((iq < -INT_LIM) ? -INT_LIM : iq[5:0]);

	assign since_off = now_ms - last_off_q;
	assign since_on = now_ms - last_on_q;
	assign mark_to = since_off >= {16'b0, cfg.lost_timeout};
	assign line_to = since_on >= {16'b0, cfg.lost_timeout};
	assign obstacle = distance_cm < cfg.min_clear_distance;
	assign mark = sensor_bits == 5'b00000;
	assign offline = sensor_bits == 5'b11111;

	always_comb begin
		integral_n = integral_q;
		prev_n = prev_q;
		station_n = station_q;
		latch_n = latch_q;
		halt_n = halt_q;
		last_on_n = last_on_q;
		last_off_n = last_off_q;
		act_n = ACT_HOLD;
		event_n = 1'b0;
		if (obstacle) begin
			act_n = ACT_STOP;
		end else begin
			if (mark) begin
				if (!latch_q) begin
					station_n = (station_q == CNT_W'(STATION_COUNT - 1)) ?
						'0 : station_q + CNT_W'(1);
					latch_n = 1'b1;
					event_n = 1'b1;
				end
				if (mark_to) begin
					halt_n = 1'b1;
					act_n = ACT_STOP;
					integral_n = '0;
				end
			end else begin
				last_off_n = now_ms;
				latch_n = 1'b0;
				halt_n = 1'b0;
			end
			if (offline) begin
				if (line_to) begin
					act_n = ACT_STOP;
					integral_n = '0;
				end
			end else if (!halt_n) begin
				last_on_n = now_ms;
				integral_n = pid_i;
				prev_n = err;
				act_n = ACT_PID;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			integral_q <= '0;
			prev_q <= '0;
			station_q <= '0;
			latch_q <= 1'b0;
			halt_q <= 1'b0;
			last_on_q <= '0;
			last_off_q <= '0;
		end else if (accept) begin
			integral_q <= integral_n;
			prev_q <= prev_n;
			station_q <= station_n;
			latch_q <= latch_n;
			halt_q <= halt_n;
			last_on_q <= last_on_n;
			last_off_q <= last_off_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_q <= '0;
		end else begin
			if (s1_ready) begin
				item_q.vld <= in_valid;
			end
			if (accept) begin
				item_q.act <= act_n;
				item_q.err <= err;
				item_q.integ <= pid_i;
				item_q.dlt <= dlt;
				item_q.station <= station_out(station_n);
				item_q.station_event <= event_n;
				item_q.halted <= halt_n;
			end
		end
	end

	`LFPD_ASSERT_NOW(a_integral_range, clk, arst_n, 1'b1,
		integral_q <= INT_LIM && integral_q >= -INT_LIM)
	`LFPD_ASSERT_NEXT(a_event_moves_station, clk, arst_n, accept && event_n,
		station_q != $past(station_q))
	`LFPD_ASSERT_NEXT(a_obstacle_keeps_state, clk, arst_n, accept && obstacle,
		$stable(integral_q) && $stable(station_q) && $stable(halt_q))

endmodule

FILE: design/lfpd_steer.sv
// Steering datapath: gain products, base offset sums, clamp and wheel/result register.
// Depends on lfpd_pkg; takes track_item_t items from lfpd_track.
`include "line_follow_pid_drive_top_assert.svh"

module lfpd_steer import lfpd_pkg::*; (
	input logic clk,
	input logic arst_n,
	input cfg_t cfg,
	input track_item_t item_s1,
	output logic take_s1,
	output logic out_valid,
	input logic out_stall,
	output logic [7:0] speed_a,
	output logic [7:0] speed_b,
	output logic [2:0] station,
	output logic station_event,
	output logic halted
);

	typedef struct packed {
		act_t act;
		logic [2:0] station;
		logic station_event;
		logic halted;
	} tag_t;

	typedef struct packed {
		tag_t tag;
		logic signed [35:0] pp_p;
		logic signed [38:0] pp_i;
		logic signed [36:0] pp_d;
	} prod_item_t;

	typedef struct packed {
		tag_t tag;
		logic signed [40:0] sum_a;
		logic signed [40:0] sum_b;
	} sum_item_t;

	logic valid_s2, valid_s3, out_valid_q;
	prod_item_t data_s2;
	sum_item_t data_s3;
	logic out_free, s3_ready, s2_ready, s3_move;
	logic signed [32:0] gp, gi, gd;
	logic signed [35:0] pp_p;
	logic signed [38:0] pp_i;
	logic signed [36:0] pp_d;
	logic signed [40:0] v, base;
	logic [7:0] speed_a_q, speed_b_q;
	logic [2:0] station_q;
	logic event_q, halted_q;

	// Floor of a Q16.16 drive value, clamped below to min, then above to max.
	function automatic logic [7:0] clamp_speed(logic signed [40:0] val, logic [7:0] lo,
			logic [7:0] hi);
		logic signed [24:0] fl;
		fl = val[40:16];
		if (fl < $signed({17'b0, lo})) begin
			return lo;
		end else if (fl > $signed({17'b0, hi})) begin
			return hi;
		end
		return fl[7:0];
	endfunction

	assign out_free = !out_valid_q || !out_stall;
	assign s3_ready = !valid_s3 || out_free;
	assign s2_ready = !valid_s2 || s3_ready;
	assign take_s1 = s2_ready;
	assign s3_move = valid_s3 && out_free;

	assign gp = $signed({1'b0, cfg.gain_p});
	assign gi = $signed({1'b0, cfg.gain_i});
	assign gd = $signed({1'b0, cfg.gain_d});
	assign pp_p = gp * item_s1.err;
	assign pp_i = gi * item_s1.integ;
	assign pp_d = gd * item_s1.dlt;

	assign v = 41'(data_s2.pp_p) + 41'(data_s2.pp_i) + 41'(data_s2.pp_d);
	assign base = $signed({17'b0, cfg.cruise_drive, 16'b0});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (s2_ready) begin
				valid_s2 <= item_s1.vld;
			end
			if (s3_ready) begin
				valid_s3 <= valid_s2;
			end
			if (out_free) begin
				out_valid_q <= valid_s3;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s2_ready && item_s1.vld) begin
			data_s2.tag.act <= item_s1.act;
			data_s2.tag.station <= item_s1.station;
			data_s2.tag.station_event <= item_s1.station_event;
			data_s2.tag.halted <= item_s1.halted;
			data_s2.pp_p <= pp_p;
			data_s2.pp_i <= pp_i;
			data_s2.pp_d <= pp_d;
		end
		if (s3_ready && valid_s2) begin
			data_s3.tag <= data_s2.tag;
			data_s3.sum_a <= base + v;
			data_s3.sum_b <= base - v;
		end
		if (s3_move) begin
			station_q <= data_s3.tag.station;
			event_q <= data_s3.tag.station_event;
			halted_q <= data_s3.tag.halted;
		end
	end

	// The wheel values are both the held state and the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			speed_a_q <= STOP_SPEED;
			speed_b_q <= STOP_SPEED;
		end else if (s3_move) begin
			case (data_s3.tag.act)
				ACT_STOP: begin
					speed_a_q <= STOP_SPEED;
					speed_b_q <= STOP_SPEED;
				end
				ACT_PID: begin
					speed_a_q <= clamp_speed(data_s3.sum_a, cfg.drive_floor,
						cfg.drive_ceiling);
					speed_b_q <= clamp_speed(data_s3.sum_b, cfg.drive_floor,
						cfg.drive_ceiling);
				end
				default: begin
					speed_a_q <= speed_a_q;
					speed_b_q <= speed_b_q;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign speed_a = speed_a_q;
	assign speed_b = speed_b_q;
	assign station = station_q;
	assign station_event = event_q;
	assign halted = halted_q;

	`LFPD_ASSERT_NEXT(a_stop_drives_stop, clk, arst_n,
		s3_move && data_s3.tag.act == ACT_STOP,
		speed_a_q == STOP_SPEED && speed_b_q == STOP_SPEED)
	`LFPD_ASSERT_NEXT(a_hold_keeps_wheels, clk, arst_n,
		s3_move && data_s3.tag.act == ACT_HOLD,
		$stable(speed_a_q) && $stable(speed_b_q))
	`LFPD_ASSERT_NEXT(a_s3_not_dropped, clk, arst_n, valid_s3 && !out_free,
		valid_s3 && $stable(data_s3))

endmodule

FILE: tb/wheel_drive_checker.sv
// Checker for line_follow_pid_drive_top: follows the register, tick and result channels.
// It keeps its own model of the controller and compares every result field by field.
// Depends on lfpd_pkg for the register layout, reset values and constants.
module wheel_drive_checker import lfpd_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic cfg_valid,
	input logic cfg_ready,
	input logic [CFG_IDX_W-1:0] cfg_index,
	input logic [31:0] cfg_data,
	input logic in_valid,
	input logic in_stall,
	input logic [4:0] sensor_bits,
	input logic [15:0] distance_cm,
	input logic [31:0] now_ms,
	input logic out_valid,
	input logic out_stall,
	input logic [7:0] speed_a,
	input logic [7:0] speed_b,
	input logic [2:0] station,
	input logic station_event,
	input logic halted,
	output int outstanding,
	output int errors
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int PRINT_LIMIT = 40;

	typedef struct packed {
		logic [7:0] speed_a;
		logic [7:0] speed_b;
		logic [2:0] station;
		logic station_event;
		logic halted;
	} drive_result_t;

	cfg_t regs;
	logic signed [5:0] integ;
	logic signed [2:0] prev_err;
	logic [CNT_W-1:0] stn_count;
	logic on_mark;
	logic halt_flag;
	logic [31:0] on_line_ms;
	logic [31:0] off_mark_ms;
	logic [7:0] wheel_a;
	logic [7:0] wheel_b;
	drive_result_t pending_results[$];
	drive_result_t want_res;
	drive_result_t next_res;

	initial errors = 0;

	task automatic log_failure(input string msg);
		if (errors < PRINT_LIMIT)
			$display("%0t ns: %s", $time, msg);
		errors++;
	endtask

	task automatic check_field(input string name, input logic [7:0] got, input logic [7:0] want);
		if (got !== want)
			log_failure($sformatf("%s is %0d, expected %0d", name, got, want));
	endtask

	// Bounds are scaled to Q16.16; the value stays nonnegative once clamped.
	function automatic logic [7:0] wheel_clamp(input longint x, input logic [7:0] lo_speed,
			input logic [7:0] hi_speed);
		longint lo;
		longint hi;
		longint y;
		lo = longint'(lo_speed) * 65536;
		hi = longint'(hi_speed) * 65536;
		y = x;
		if (y < lo)
			y = lo;
		else if (y > hi)
			y = hi;
		return 8'(y / 65536);
	endfunction

	task automatic advance_tick(input logic [4:0] bits, input logic [15:0] range_cm,
			input logic [31:0] now, output drive_result_t res);
		int sum;
		int e;
		int i_next;
		int d;
		longint v;
		longint base;
		logic advanced;
		sum = 0;
		advanced = 1'b0;
		if (range_cm < regs.min_clear_distance) begin
			wheel_a = STOP_SPEED;
			wheel_b = STOP_SPEED;
		end else begin
			for (int k = 0; k < 5; k++)
				if (!bits[k])
					sum += k - 2;
			if (bits == 5'b00000) begin
				if (!on_mark) begin
					if (int'(stn_count) + 1 >= STATION_COUNT)
						stn_count = '0;
					else
						stn_count = stn_count + 1'b1;
					on_mark = 1'b1;
					advanced = 1'b1;
				end
				if (now - off_mark_ms >= 32'(regs.lost_timeout)) begin
					halt_flag = 1'b1;
					wheel_a = STOP_SPEED;
					wheel_b = STOP_SPEED;
					integ = '0;
				end
			end else begin
				off_mark_ms = now;
				on_mark = 1'b0;
				halt_flag = 1'b0;
			end
			if (bits == 5'b11111) begin
				if (now - on_line_ms >= 32'(regs.lost_timeout)) begin
					wheel_a = STOP_SPEED;
					wheel_b = STOP_SPEED;
					integ = '0;
				end
			end else if (!halt_flag) begin
				on_line_ms = now;
				// The sum-to-error map is not monotonic at the outer sensors.
				case (sum)
					-3: e = -2;
					-2: e = -3;
					-1: e = -1;
					1: e = 1;
					2: e = 3;
					3: e = 2;
					default: e = 0;
				endcase
				i_next = (9 * int'(integ) + 10 * e) / 10;
				if (i_next > int'(INT_LIM))
					i_next = int'(INT_LIM);
				else if (i_next < -int'(INT_LIM))
					i_next = -int'(INT_LIM);
				integ = i_next[5:0];
				d = e - int'(prev_err);
				v = longint'(regs.gain_p) * e + longint'(regs.gain_i) * i_next
					+ longint'(regs.gain_d) * d;
				base = longint'(regs.cruise_drive) * 65536;
				wheel_a = wheel_clamp(base + v, regs.drive_floor, regs.drive_ceiling);
				wheel_b = wheel_clamp(base - v, regs.drive_floor, regs.drive_ceiling);
				prev_err = e[2:0];
			end
		end
		res.speed_a = wheel_a;
		res.speed_b = wheel_b;
		res.station = 3'(stn_count);
		res.station_event = advanced;
		res.halted = halt_flag;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs = '{gain_p: GAIN_P_RST, gain_i: GAIN_I_RST, gain_d: GAIN_D_RST,
				min_clear_distance: MIN_CLEAR_RST, lost_timeout: LOST_TIMEOUT_RST,
				cruise_drive: CRUISE_DRIVE_RST, drive_floor: DRIVE_FLOOR_RST,
				drive_ceiling: DRIVE_CEILING_RST};
			integ = '0;
			prev_err = '0;
			stn_count = '0;
			on_mark = 1'b0;
			halt_flag = 1'b0;
			on_line_ms = '0;
			off_mark_ms = '0;
			wheel_a = STOP_SPEED;
			wheel_b = STOP_SPEED;
			pending_results.delete();
			outstanding <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_reg_t'(cfg_index))
					REG_GAIN_P: regs.gain_p = cfg_data;
					REG_GAIN_I: regs.gain_i = cfg_data;
					REG_GAIN_D: regs.gain_d = cfg_data;
					REG_MIN_CLEAR: regs.min_clear_distance = cfg_data[15:0];
					REG_LOST_TIMEOUT: regs.lost_timeout = cfg_data[15:0];
					REG_CRUISE_DRIVE: regs.cruise_drive = cfg_data[7:0];
					REG_DRIVE_FLOOR: regs.drive_floor = cfg_data[7:0];
					REG_DRIVE_CEILING: regs.drive_ceiling = cfg_data[7:0];
					default: ;
				endcase
			end
			// Results are matched before the new tick is queued, so a result can
			// never be paired with a tick accepted at the same edge.
			if (out_valid && !out_stall) begin
				if (pending_results.size() == 0) begin
					log_failure($sformatf("result transaction with nothing expected (%0d/%0d)",
						speed_a, speed_b));
				end else begin
					want_res = pending_results.pop_front();
					check_field("speed_a", speed_a, want_res.speed_a);
					check_field("speed_b", speed_b, want_res.speed_b);
					check_field("station", station, want_res.station);
					check_field("station_event", station_event, want_res.station_event);
					check_field("halted", halted, want_res.halted);
				end
			end
			if (in_valid && !in_stall) begin
				advance_tick(sensor_bits, distance_cm, now_ms, next_res);
				pending_results.push_back(next_res);
			end
			outstanding <= pending_results.size();
		end
	end

endmodule

FILE: tb/testbench.sv
// Top of the line follower drive testbench: clock, reset, tick and register stimulus.
// Depends on lfpd_pkg, line_follow_pid_drive_top and wheel_drive_checker.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import lfpd_pkg::*;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int SETTLE_CYCLES = 8;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [31:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [4:0] sensor_bits = '0;
	logic [15:0] distance_cm = '0;
	logic [31:0] now_ms = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [7:0] speed_a;
	logic [7:0] speed_b;
	logic [2:0] station;
	logic station_event;
	logic halted;
	int outstanding;
	int errors;

	int quiet_cycles = 0;
	int tx_gap_pct = 0;
	int rx_stall_pct = 0;
	cfg_t active_cfg;
	logic [31:0] clock_ms = '0;

	line_follow_pid_drive_top dut (.*);

	wheel_drive_checker checker_i (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Counts cycles without any transaction on any channel.
	always @(posedge clk) begin
		if ((cfg_valid && cfg_ready) || (in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("testbench NOT OK");
			$finish;
		end
	end

	initial begin
		forever begin
			@(posedge clk);
			if (rx_stall_pct != 0 && $urandom_range(99) < rx_stall_pct) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(18, 1)) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	task automatic send_tick(input logic [4:0] bits, input logic [15:0] range_cm,
			input logic [31:0] now);
		if (tx_gap_pct != 0 && $urandom_range(99) < tx_gap_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(18, 1)) @(posedge clk);
		end
		in_valid <= 1'b1;
		sensor_bits <= bits;
		distance_cm <= range_cm;
		now_ms <= now;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic pause_until_drained();
		in_valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
	endtask

	// Bits above the register width carry random junk; the block must ignore them.
	task automatic write_reg(input cfg_reg_t idx, input logic [31:0] value, input int width);
		logic [31:0] keep;
		keep = (width == 32) ? 32'hFFFF_FFFF : (32'd1 << width) - 1;
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= (value & keep) | ($urandom & ~keep);
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic load_settings(input cfg_t s);
		write_reg(REG_GAIN_P, s.gain_p, 32);
		write_reg(REG_GAIN_I, s.gain_i, 32);
		write_reg(REG_GAIN_D, s.gain_d, 32);
		write_reg(REG_MIN_CLEAR, 32'(s.min_clear_distance), 16);
		write_reg(REG_LOST_TIMEOUT, 32'(s.lost_timeout), 16);
		write_reg(REG_CRUISE_DRIVE, 32'(s.cruise_drive), 8);
		write_reg(REG_DRIVE_FLOOR, 32'(s.drive_floor), 8);
		write_reg(REG_DRIVE_CEILING, 32'(s.drive_ceiling), 8);
		cfg_valid <= 1'b0;
		active_cfg = s;
	endtask

	// Runs of line tracking, held station marks, lost line and obstacles,
	// with a little noise that jumps the timestamp anywhere.
	task automatic run_phase(input int ticks, input int max_step);
		int kind;
		int run_len;
		int width;
		int sent;
		logic [4:0] bits;
		logic [4:0] stripe;
		logic [15:0] range_cm;
		sent = 0;
		while (sent < ticks) begin
			kind = $urandom_range(99);
			run_len = $urandom_range(10, 1);
			for (int n = 0; n < run_len && sent < ticks; n++) begin
				clock_ms += $urandom_range(max_step, 0);
				if ($urandom_range(9) == 0)
					range_cm = active_cfg.min_clear_distance;
				else
					range_cm = 16'($urandom_range(65535, active_cfg.min_clear_distance));
				if (kind < 45) begin
					if ($urandom_range(99) < 70) begin
						width = $urandom_range(3, 1);
						stripe = 5'((1 << width) - 1) << $urandom_range(5 - width, 0);
						bits = ~stripe;
					end else begin
						bits = 5'($urandom);
					end
				end else if (kind < 62) begin
					bits = 5'b00000;
				end else if (kind < 78) begin
					bits = 5'b11111;
				end else if (kind < 90) begin
					bits = 5'($urandom);
					if (active_cfg.min_clear_distance != 0) begin
						if ($urandom_range(1) == 0)
							range_cm = active_cfg.min_clear_distance - 16'd1;
						else
							range_cm = 16'($urandom_range(
								active_cfg.min_clear_distance - 1, 0));
					end
				end else begin
					bits = 5'($urandom);
					range_cm = 16'($urandom);
					clock_ms = $urandom;
				end
				send_tick(bits, range_cm, clock_ms);
				sent++;
			end
		end
	endtask

	initial begin
		cfg_t s;
		int ticks;
		int max_step;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		active_cfg = '{gain_p: GAIN_P_RST, gain_i: GAIN_I_RST, gain_d: GAIN_D_RST,
			min_clear_distance: MIN_CLEAR_RST, lost_timeout: LOST_TIMEOUT_RST,
			cruise_drive: CRUISE_DRIVE_RST, drive_floor: DRIVE_FLOOR_RST,
			drive_ceiling: DRIVE_CEILING_RST};
		@(posedge clk);
		tx_gap_pct = 20;
		rx_stall_pct = 6;

		// Directed ticks at reset settings: each sensor, the outer pairs, obstacle
		// edges, a station mark held to the timeout and beyond, lost line on both
		// sides of the timeout, and a timestamp that wraps.
		send_tick(5'b11011, 16'd100, 32'd10);
		send_tick(5'b11110, 16'd100, 32'd20);
		send_tick(5'b11101, 16'd100, 32'd30);
		send_tick(5'b10111, 16'd100, 32'd40);
		send_tick(5'b01111, 16'd100, 32'd50);
		send_tick(5'b11100, 16'd100, 32'd60);
		send_tick(5'b00111, 16'd100, 32'd70);
		send_tick(5'b11001, 16'd100, 32'd80);
		send_tick(5'b10011, 16'd100, 32'd90);
		send_tick(5'b01111, 16'd19, 32'd100);
		send_tick(5'b01111, 16'd20, 32'd110);
		send_tick(5'b11011, 16'd0, 32'd120);
		send_tick(5'b00000, 16'd100, 32'd200);
		send_tick(5'b00000, 16'd100, 32'd3109);
		send_tick(5'b00000, 16'd100, 32'd3110);
		send_tick(5'b00000, 16'd100, 32'd3200);
		send_tick(5'b11011, 16'd100, 32'd3300);
		send_tick(5'b11111, 16'd100, 32'd6299);
		send_tick(5'b11111, 16'd100, 32'd6300);
		send_tick(5'b11011, 16'd65535, 32'hFFFF_FFF0);
		send_tick(5'b11111, 16'd65535, 32'h0000_0010);
		send_tick(5'b00000, 16'd65535, 32'h0000_0020);
		send_tick(5'b01010, 16'd500, 32'h0000_0030);
		pause_until_drained();
		clock_ms = 32'h0000_0030;

		for (int p = 0; p < 9; p++) begin
			s.gain_p = $urandom_range(32'h0008_0000);
			s.gain_i = $urandom_range(32'h0004_0000);
			s.gain_d = $urandom_range(32'h0020_0000);
			s.min_clear_distance = 16'($urandom_range(200));
			s.lost_timeout = 16'($urandom_range(60));
			s.cruise_drive = 8'($urandom_range(120, 60));
			s.drive_floor = 8'($urandom_range(80, 40));
			s.drive_ceiling = 8'($urandom_range(160, 80));
			ticks = 150;
			max_step = 20;
			tx_gap_pct = 15;
			rx_stall_pct = 5;
			case (p)
				0: begin
					s = active_cfg;
					ticks = 120;
					max_step = 700;
					tx_gap_pct = 20;
					rx_stall_pct = 6;
				end
				1: begin
					s = '0;
					ticks = 100;
					max_step = 3;
				end
				2: begin
					s = '1;
					ticks = 40;
					max_step = 40000;
					tx_gap_pct = 0;
					rx_stall_pct = 0;
				end
				3: begin
					// Lower clamp above the upper one.
					s.min_clear_distance = 16'd10;
					s.lost_timeout = 16'd20;
					s.cruise_drive = 8'd120;
					s.drive_floor = 8'd200;
					s.drive_ceiling = 8'd50;
					ticks = 120;
					max_step = 15;
					tx_gap_pct = 25;
					rx_stall_pct = 10;
				end
				5: begin
					s.gain_p = $urandom;
					s.gain_i = $urandom;
					s.gain_d = $urandom;
					s.min_clear_distance = 16'($urandom_range(300));
					s.lost_timeout = 16'($urandom_range(200));
					s.cruise_drive = 8'($urandom);
					s.drive_floor = 8'($urandom);
					s.drive_ceiling = 8'($urandom);
					max_step = 40;
					tx_gap_pct = 10;
					rx_stall_pct = 3;
				end
				6: begin
					tx_gap_pct = 40;
					rx_stall_pct = 15;
				end
				7: begin
					clock_ms = 32'hFFFF_FF00;
					ticks = 120;
				end
				8: begin
					tx_gap_pct = 0;
					rx_stall_pct = 0;
				end
				default: ;
			endcase
			if (p != 0)
				load_settings(s);
			if (p == 4) begin
				// Let the pipeline run dry in the middle of a phase.
				run_phase(ticks / 2, max_step);
				pause_until_drained();
				run_phase(ticks - ticks / 2, max_step);
			end else begin
				run_phase(ticks, max_step);
			end
			pause_until_drained();
		end

		repeat (SETTLE_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("testbench OK");
		else
			$display("testbench NOT OK");
		$finish;
	end

endmodule
